/* hw/rtl/pba_pkg.sv */
// Shared types, codes and helpers for the page bitmap allocator.
`default_nettype none

package pba_pkg;

    localparam int unsigned CFG_W     = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned PAGE_W    = 15;
    localparam int unsigned WORD_W    = 32;

    localparam logic [CFG_W-1:0] MAP_WORDS_RST = 11'd1024;
    localparam logic [CFG_W-1:0] RSV_WORDS_RST = 11'd0;

    localparam logic [WORD_W-1:0] FULL_WORD = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] ONE_BIT   = 32'h0000_0001;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WORDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV_WORDS = 2'd1;

    // operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_MARK  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PAGES = 2'd1;
    localparam logic [1:0] ST_ALREADY  = 2'd2;

    // classified request, as it travels from front to back
    typedef struct packed {
        logic [1:0]        op;
        logic [PAGE_W-1:0] page;
        logic              in_range;  // word lies below the map limit
        logic              rsv;       // word lies in the reserved area
        logic              none;      // allocate has nothing to scan
    } t_cmd;

    // index of the lowest set bit, zero when none is set
    function automatic logic [4:0] low_set(input logic [WORD_W-1:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = 5'(k);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pba_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/pba_front.sv */
// Front stage: take requests, classify them and hand them to the queue.
`default_nettype none

module pba_front
    import pba_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_clearing,
    input  wire logic              i_start,
    input  wire logic [1:0]        i_operation,
    input  wire logic [PAGE_W-1:0] i_page_number,
    input  wire logic [CFG_W-1:0]  i_limit,
    input  wire logic [CFG_W-1:0]  i_reserved,
    input  wire logic              i_q_full,
    output logic                   o_busy,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    logic       r_valid;
    t_cmd       r_cmd;
    logic       take;
    logic [CFG_W-1:0] word;

    assign o_busy = i_clearing || (r_valid && i_q_full);
    assign take   = i_start && !o_busy;
    assign o_push = r_valid && !i_q_full;
    assign o_cmd  = r_cmd;
    assign word   = CFG_W'(i_page_number[PAGE_W-1:5]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // classify on entry; the user must keep config stable while requests are in flight, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd.op       <= i_operation;
            r_cmd.page     <= i_page_number;
            r_cmd.in_range <= word < i_limit;
            r_cmd.rsv      <= word < i_reserved;
            r_cmd.none     <= i_reserved >= i_limit;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pba_queue.sv */
// Two-entry show-ahead queue between front and back.
`default_nettype none

module pba_queue
    import pba_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_head
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pba_back.sv */
// Back end: bitmap and full-word summary memories, scan and update sequencer.
`default_nettype none

module pba_back
    import pba_pkg::*;
#(
    parameter int unsigned MAP_WORDS = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CFG_W-1:0]  i_limit,
    input  wire logic [CFG_W-1:0]  i_reserved,
    input  wire logic              i_empty,
    input  wire t_cmd              i_head,
    output logic                   o_pop,
    output logic                   o_clearing,
    output logic                   o_done,
    output logic [PAGE_W-1:0]      o_page_out,
    output logic [1:0]             o_status
);

    localparam int unsigned AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned GROUPS = (MAP_WORDS + WORD_W - 1) / WORD_W;
    localparam int unsigned GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int unsigned GRP_W  = CFG_W - 5;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_GRANT  = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    t_cmd              r_cmd, n_cmd;
    logic [GRP_W-1:0]  r_g, n_g;
    logic [4:0]        r_i, n_i;
    logic [WORD_W-1:0] r_sum, n_sum;
    logic              r_done, n_done;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [1:0]        r_status, n_status;

    logic              d_we, s_we;
    logic [AW-1:0]     d_waddr, d_raddr;
    logic [GW-1:0]     s_waddr, s_raddr;
    logic [WORD_W-1:0] d_wdata, s_wdata, d_rdata, s_rdata;

    logic [CFG_W-1:0]  lm1;
    logic [GRP_W-1:0]  rg, lg;
    logic [WORD_W-1:0] lomask, himask, cand, pmask, gmask, nv;
    logic [4:0]        b;

    pba_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_bits (
        .i_clk  (i_clk),
        .i_we   (d_we),
        .i_waddr(d_waddr),
        .i_wdata(d_wdata),
        .i_raddr(d_raddr),
        .o_rdata(d_rdata)
    );

    pba_ram #(.WIDTH(WORD_W), .DEPTH(GROUPS)) u_summary (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    assign o_clearing = r_state == S_CLEAR;
    assign o_done     = r_done;
    assign o_page_out = r_page;
    assign o_status   = r_status;

    always_comb begin
        lm1    = i_limit - CFG_W'(1);
        rg     = i_reserved[CFG_W-1:5];
        lg     = lm1[CFG_W-1:5];
        lomask = (r_g == rg) ? (FULL_WORD << i_reserved[4:0]) : FULL_WORD;
        himask = (r_g == lg) ? (FULL_WORD >> (5'd31 - lm1[4:0])) : FULL_WORD;
        cand   = ~s_rdata & lomask & himask;
        pmask  = ONE_BIT << r_cmd.page[4:0];
        gmask  = ONE_BIT << r_cmd.page[9:5];
        b      = low_set(~d_rdata);
        nv     = '0;

        n_state  = r_state;
        n_clr    = r_clr;
        n_cmd    = r_cmd;
        n_g      = r_g;
        n_i      = r_i;
        n_sum    = r_sum;
        n_done   = 1'b0;
        n_page   = r_page;
        n_status = r_status;
        o_pop    = 1'b0;

        // default reads serve the request waiting at the queue head
        d_raddr = AW'(i_head.page[PAGE_W-1:5]);
        s_raddr = GW'(i_head.page[PAGE_W-1:10]);
        d_we    = 1'b0;
        s_we    = 1'b0;
        d_waddr = AW'(r_cmd.page[PAGE_W-1:5]);
        s_waddr = GW'(r_cmd.page[PAGE_W-1:10]);
        d_wdata = '0;
        s_wdata = '0;

        case (r_state)
            S_CLEAR: begin
                // sweep both memories to zero, one word a cycle
                d_we    = 1'b1;
                s_we    = 1'b1;
                d_waddr = r_clr;
                s_waddr = GW'(r_clr);
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_head;
                    n_page = i_head.page;
                    case (i_head.op)
                        OP_ALLOC: begin
                            if (i_head.none) begin
                                n_done   = 1'b1;
                                n_page   = '0;
                                n_status = ST_NO_PAGES;
                            end else begin
                                n_g     = rg;
                                s_raddr = GW'(rg);
                                n_state = S_SCAN;
                            end
                        end
                        OP_FREE: begin
                            if (i_head.in_range) begin
                                n_state = S_UPDATE;
                            end else begin
                                n_done   = 1'b1;
                                n_status = ST_OK;
                            end
                        end
                        OP_MARK: begin
                            if (i_head.in_range && !i_head.rsv) begin
                                n_state = S_UPDATE;
                            end else begin
                                n_done   = 1'b1;
                                n_status = i_head.in_range ? ST_ALREADY : ST_OK;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // one summary group a cycle; the next read goes out at once
                if (cand != '0) begin
                    n_i     = low_set(cand);
                    n_sum   = s_rdata;
                    d_raddr = AW'({r_g, n_i});
                    n_state = S_GRANT;
                end else if (r_g == lg) begin
                    n_done   = 1'b1;
                    n_page   = '0;
                    n_status = ST_NO_PAGES;
                    n_state  = S_IDLE;
                end else begin
                    n_g     = r_g + GRP_W'(1);
                    s_raddr = GW'(n_g);
                end
            end
            S_GRANT: begin
                nv       = d_rdata | (ONE_BIT << b);
                d_we     = 1'b1;
                s_we     = 1'b1;
                d_waddr  = AW'({r_g, r_i});
                s_waddr  = GW'(r_g);
                d_wdata  = nv;
                s_wdata  = (nv == FULL_WORD) ? (r_sum | (ONE_BIT << r_i)) : r_sum;
                n_done   = 1'b1;
                n_page   = PAGE_W'({r_g, r_i, b});
                n_status = ST_OK;
                n_state  = S_IDLE;
            end
            S_UPDATE: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_cmd.op == OP_FREE) begin
                    d_we     = 1'b1;
                    s_we     = 1'b1;
                    d_wdata  = d_rdata & ~pmask;
                    s_wdata  = s_rdata & ~gmask;
                    n_status = ST_OK;
                end else if ((d_rdata & pmask) != '0) begin
                    n_status = ST_ALREADY;
                end else begin
                    nv       = d_rdata | pmask;
                    d_we     = 1'b1;
                    s_we     = 1'b1;
                    d_wdata  = nv;
                    s_wdata  = (nv == FULL_WORD) ? (s_rdata | gmask) : s_rdata;
                    n_status = ST_OK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_g      <= n_g;
        r_i      <= n_i;
        r_sum    <= n_sum;
        r_page   <= n_page;
        r_status <= n_status;
    end

endmodule

`default_nettype wire

/* hw/rtl/page_bitmap_allocator.sv */
// Top level of the first-fit page bitmap allocator.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-----------------------------------
//  request   | i_start, o_busy              | i_operation, i_page_number
//  result    | o_done (one-cycle strobe)    | o_page_out, o_status
//  config    | i_cfg_valid, o_cfg_ready     | i_cfg_index, i_cfg_data
//
// A request is taken at a clock edge with i_start high and o_busy low. The front
// stage registers and classifies it, then it waits in a two-entry queue until
// the back end is free. An in-range free or mark then passes through the back
// end's idle and update states, while a request settled by its classification
// alone is answered from the idle state. An allocate scans the summary one
// 32-word group at a time from the reserved boundary (up to 32 groups at 1024
// words), as there is a single summary read port, and either grants from the
// bitmap word it found or reports no pages. Requests queued behind a busy back
// end wait their turn. After reset the back end sweeps both memories to zero
// and holds o_busy high meanwhile; configuration writes are taken as ever.
// Results are strobed for one cycle and cannot be held off by the receiver.
`default_nettype none

module page_bitmap_allocator
    import pba_pkg::*;
#(
    parameter int unsigned MAP_WORDS = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic [1:0]           i_operation,
    input  wire logic [PAGE_W-1:0]    i_page_number,
    // result channel
    output logic                      o_done,
    output logic [PAGE_W-1:0]         o_page_out,
    output logic [1:0]                o_status,
    // configuration channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic [16:0] MAPW = 17'(MAP_WORDS);

    logic [CFG_W-1:0] r_map_words;
    logic [CFG_W-1:0] r_rsv_words;
    logic [CFG_W-1:0] limit;

    logic q_full, q_empty, q_push, q_pop, clearing;
    t_cmd front_cmd, head_cmd;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_words <= MAP_WORDS_RST;
            r_rsv_words <= RSV_WORDS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAP_WORDS: r_map_words <= i_cfg_data;
                CFG_RSV_WORDS: r_rsv_words <= i_cfg_data;
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    // clamp the map to the storage actually built
    assign limit = (17'(r_map_words) > MAPW) ? CFG_W'(MAPW) : r_map_words;

    pba_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clearing   (clearing),
        .i_start      (i_start),
        .i_operation  (i_operation),
        .i_page_number(i_page_number),
        .i_limit      (limit),
        .i_reserved   (r_rsv_words),
        .i_q_full     (q_full),
        .o_busy       (o_busy),
        .o_push       (q_push),
        .o_cmd        (front_cmd)
    );

    pba_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (front_cmd),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_head (head_cmd)
    );

    pba_back #(.MAP_WORDS(MAP_WORDS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_limit   (limit),
        .i_reserved(r_rsv_words),
        .i_empty   (q_empty),
        .i_head    (head_cmd),
        .o_pop     (q_pop),
        .o_clearing(clearing),
        .o_done    (o_done),
        .o_page_out(o_page_out),
        .o_status  (o_status)
    );

endmodule

`default_nettype wire
